[sv/m4i_pkg.sv]
// m4i_pkg: shared widths, command and status types and microcode tables
// for the 4x4 cofactor inverse. No dependencies.
package m4i_pkg;

  // fixed point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int FRAC2     = 2 * FRAC_BITS;
  localparam int ELEM_W    = 32;
  localparam int HALF_W    = 32;
  localparam int COF_W     = 64;
  localparam int MINOR_W   = 65;
  localparam int OPND_W    = 33;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int BIG_W     = 100;
  localparam int QUO_W     = 33;
  localparam int DIV_W     = BIG_W + QUO_W;
  localparam int NUM_W     = COF_W + FRAC2;
  localparam int ITER_W    = $clog2(QUO_W + 1);
  localparam int DET_LAST  = 10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MINOR_SET,
    OP_MINOR_SUB,
    OP_BIG,
    OP_WR_COF,
    OP_DET_LATCH,
    OP_DIV_START,
    OP_EMIT,
    OP_EMIT_SING
  } op_e;

  typedef enum logic [2:0] {
    BSEL_MAT,
    BSEL_MIN_LO,
    BSEL_MIN_HI,
    BSEL_COF_LO,
    BSEL_COF_HI
  } bsel_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] addr_a;
    logic [3:0] addr_b;
    logic [3:0] cof_addr;
    bsel_e      bsel;
    logic       neg;
    logic       shift_hi;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic det_zero;
  } stat_t;

  function automatic cmd_t cmd_idle();
    cmd_t c;
    c          = '0;
    c.op       = OP_NONE;
    c.bsel     = BSEL_MAT;
    return c;
  endfunction

  // n-th index of 0..3 with one index left out
  function automatic logic [1:0] other_idx(input logic [1:0] skip, input logic [1:0] n);
    logic [1:0] r;
    r = n + ((n >= skip) ? 2'd1 : 2'd0);
    return r;
  endfunction

  // microcode for adjugate entry k, slot s (16 slots per entry)
  function automatic cmd_t cof_cmd(input logic [3:0] k, input logic [3:0] s);
    cmd_t       c;
    logic [1:0] dr;
    logic [1:0] dc;
    logic [1:0] t;
    logic [3:0] u;
    logic [1:0] r0;
    logic [1:0] r1;
    logic [1:0] r2;
    logic [1:0] ct;
    logic [1:0] ca;
    logic [1:0] cb;
    logic       tsign;
    c  = cmd_idle();
    dr = k[1:0];
    dc = k[3:2];
    if (s < 4'd5) begin
      t = 2'd0;
      u = s;
    end else if (s < 4'd10) begin
      t = 2'd1;
      u = s - 4'd5;
    end else begin
      t = 2'd2;
      u = s - 4'd10;
    end
    r0    = other_idx(dr, 2'd0);
    r1    = other_idx(dr, 2'd1);
    r2    = other_idx(dr, 2'd2);
    ct    = other_idx(dc, t);
    ca    = other_idx(dc, (t == 2'd0) ? 2'd1 : 2'd0);
    cb    = other_idx(dc, (t == 2'd2) ? 2'd1 : 2'd2);
    tsign = t[0] ^ k[2] ^ k[0];
    if (s == 4'd15) begin
      c.op       = OP_WR_COF;
      c.cof_addr = k;
    end else begin
      unique case (u)
        4'd0: begin
          c.op     = OP_MINOR_SET;
          c.addr_a = {r1, ca};
          c.addr_b = {r2, cb};
        end
        4'd1: begin
          c.op     = OP_MINOR_SUB;
          c.addr_a = {r1, cb};
          c.addr_b = {r2, ca};
        end
        4'd3: begin
          c.op     = OP_BIG;
          c.addr_a = {r0, ct};
          c.bsel   = BSEL_MIN_LO;
          c.neg    = tsign;
          c.clear  = (t == 2'd0);
        end
        4'd4: begin
          c.op       = OP_BIG;
          c.addr_a   = {r0, ct};
          c.bsel     = BSEL_MIN_HI;
          c.neg      = tsign;
          c.shift_hi = 1'b1;
        end
        default: c.op = OP_NONE;
      endcase
    end
    return c;
  endfunction

  // microcode for the determinant along row zero
  function automatic cmd_t det_cmd(input logic [3:0] s);
    cmd_t c;
    c = cmd_idle();
    if (s < 4'd8) begin
      c.op       = OP_BIG;
      c.addr_a   = {2'd0, s[2:1]};
      c.cof_addr = {s[2:1], 2'b00};
      c.bsel     = s[0] ? BSEL_COF_HI : BSEL_COF_LO;
      c.shift_hi = s[0];
      c.clear    = (s == 4'd0);
    end else if (s == 4'd8) begin
      c.op = OP_DET_LATCH;
    end
    return c;
  endfunction

endpackage

[sv/m4i_ram.sv]
// m4i_ram: generic single write, single read RAM with registered read.
// No dependencies.
module m4i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/m4i_datapath.sv]
// m4i_datapath: element and adjugate stores, shared 33x33 multiplier with
// accumulators, determinant latch, restoring divider and result register.
// Depends on m4i_pkg and m4i_ram.
module m4i_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  m4i_pkg::cmd_t                cmd_i,
  input  logic [m4i_pkg::ELEM_W-1:0]   element_value_i,
  output m4i_pkg::stat_t               stat_o,
  output logic [m4i_pkg::ELEM_W-1:0]   result_value_o,
  output logic [3:0]                   result_index_o,
  output logic                         singular_o,
  output logic                         overflowed_o,
  output logic                         last_result_o
);
  import m4i_pkg::*;

  logic [ELEM_W-1:0]      rd_a;
  logic [ELEM_W-1:0]      rd_b;
  logic [COF_W:0]         cof_rd;
  logic [COF_W:0]         cof_wdata;
  cmd_t                   c1_q;
  cmd_t                   c2_q;
  logic signed [OPND_W-1:0] opa;
  logic signed [OPND_W-1:0] opb;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic [MINOR_W-1:0]     minor_q;
  logic signed [BIG_W-1:0] big_q;
  logic signed [BIG_W-1:0] big_d;
  logic signed [BIG_W-1:0] big_base;
  logic signed [BIG_W-1:0] big_delta;
  logic signed [BIG_W-1:0] big_sh;
  logic                   cof_fit;
  logic [COF_W-1:0]       cof_sat;
  logic                   det_neg_q;
  logic                   det_zero_q;
  logic [BIG_W-1:0]       dmag_q;
  logic [COF_W-1:0]       cof_mag;
  logic                   cof_neg_q;
  logic                   clamp_q;
  logic [DIV_W-1:0]       rem_q;
  logic [DIV_W-1:0]       dsh_q;
  logic [QUO_W-1:0]       quo_q;
  logic [ITER_W-1:0]      iter_q;
  logic                   rem_ge;
  logic                   rneg;
  logic                   rsat;
  logic [ELEM_W-1:0]      rval;
  logic [ELEM_W-1:0]      result_value_q;
  logic [3:0]             result_index_q;
  logic                   singular_q;
  logic                   overflowed_q;
  logic                   last_result_q;

  // element store, two copies for two read ports
  m4i_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_mat_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_LOAD),
    .waddr_i (cmd_i.addr_a),
    .wdata_i (element_value_i),
    .raddr_i (cmd_i.addr_a),
    .rdata_o (rd_a)
  );

  m4i_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_mat_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_LOAD),
    .waddr_i (cmd_i.addr_a),
    .wdata_i (element_value_i),
    .raddr_i (cmd_i.addr_b),
    .rdata_o (rd_b)
  );

  // adjugate store, clamp mark in the top bit
  m4i_ram #(.WIDTH(COF_W + 1), .DEPTH(16)) u_cof (
    .clk_i   (clk_i),
    .we_i    (c2_q.op == OP_WR_COF),
    .waddr_i (c2_q.cof_addr),
    .wdata_i (cof_wdata),
    .raddr_i (cmd_i.cof_addr),
    .rdata_o (cof_rd)
  );

  // command pipe: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= cmd_idle();
      c2_q <= cmd_idle();
    end else begin
      c1_q <= cmd_i;
      c2_q <= c1_q;
    end
  end

  // multiplier operands
  always_comb begin
    opa = $signed({rd_a[ELEM_W-1], rd_a});
    unique case (c1_q.bsel)
      BSEL_MAT:    opb = $signed({rd_b[ELEM_W-1], rd_b});
      BSEL_MIN_LO: opb = $signed({1'b0, minor_q[HALF_W-1:0]});
      BSEL_MIN_HI: opb = $signed(minor_q[MINOR_W-1:HALF_W]);
      BSEL_COF_LO: opb = $signed({1'b0, cof_rd[HALF_W-1:0]});
      BSEL_COF_HI: opb = $signed({cof_rd[COF_W-1], cof_rd[COF_W-1:HALF_W]});
      default:     opb = '0;
    endcase
    prod_d = opa * opb;
  end

  always_ff @(posedge clk_i) begin
    if (c1_q.op == OP_MINOR_SET || c1_q.op == OP_MINOR_SUB || c1_q.op == OP_BIG) begin
      prod_q <= prod_d;
    end
  end

  // wide accumulator update
  always_comb begin
    big_base  = c2_q.clear ? '0 : big_q;
    if (c2_q.shift_hi) begin
      big_delta = $signed({{(BIG_W-PROD_W-HALF_W){prod_q[PROD_W-1]}}, prod_q,
                           {HALF_W{1'b0}}});
    end else begin
      big_delta = $signed({{(BIG_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
    end
    big_d = c2_q.neg ? (big_base - big_delta) : (big_base + big_delta);
  end

  // floor shift by 2F and clamp to 64 bits
  always_comb begin
    big_sh  = big_q >>> FRAC2;
    cof_fit = (&big_sh[BIG_W-1:COF_W-1]) | ~(|big_sh[BIG_W-1:COF_W-1]);
    if (cof_fit) begin
      cof_sat = big_sh[COF_W-1:0];
    end else if (big_q[BIG_W-1]) begin
      cof_sat = {1'b1, {(COF_W-1){1'b0}}};
    end else begin
      cof_sat = {1'b0, {(COF_W-1){1'b1}}};
    end
    cof_wdata = {~cof_fit, cof_sat};
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    unique case (c2_q.op)
      OP_MINOR_SET: minor_q <= prod_q[MINOR_W-1:0];
      OP_MINOR_SUB: minor_q <= minor_q - prod_q[MINOR_W-1:0];
      OP_BIG:       big_q   <= big_d;
      default: ;
    endcase
  end

  // determinant sign, magnitude and zero flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_zero_q <= 1'b0;
    end else if (c2_q.op == OP_DET_LATCH) begin
      det_zero_q <= (big_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (c2_q.op == OP_DET_LATCH) begin
      det_neg_q <= big_q[BIG_W-1];
      dmag_q    <= big_q[BIG_W-1] ? BIG_W'(-big_q) : BIG_W'(big_q);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign cof_mag = cof_rd[COF_W-1] ? (~cof_rd[COF_W-1:0] + 1'b1) : cof_rd[COF_W-1:0];
  assign rem_ge  = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (c1_q.op == OP_DIV_START) begin
      iter_q <= ITER_W'(QUO_W);
    end else if (iter_q != '0) begin
      iter_q <= iter_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c1_q.op == OP_DIV_START) begin
      cof_neg_q <= cof_rd[COF_W-1];
      clamp_q   <= cof_rd[COF_W];
      rem_q     <= {{(DIV_W-NUM_W){1'b0}}, cof_mag, {FRAC2{1'b0}}};
      dsh_q     <= {1'b0, dmag_q, {(QUO_W-1){1'b0}}};
      quo_q     <= '0;
    end else if (iter_q != '0) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // signed, saturated quotient
  always_comb begin
    rneg = cof_neg_q ^ det_neg_q;
    if (rneg) begin
      rsat = quo_q[QUO_W-1] | (quo_q[ELEM_W-1] & (|quo_q[ELEM_W-2:0]));
    end else begin
      rsat = quo_q[QUO_W-1] | quo_q[ELEM_W-1];
    end
    if (rsat) begin
      rval = rneg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
    end else begin
      rval = rneg ? (~quo_q[ELEM_W-1:0] + 1'b1) : quo_q[ELEM_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      result_value_q <= rval;
      result_index_q <= cmd_i.cof_addr;
      singular_q     <= 1'b0;
      overflowed_q   <= rsat | clamp_q;
      last_result_q  <= (cmd_i.cof_addr == 4'hF);
    end else if (cmd_i.op == OP_EMIT_SING) begin
      result_value_q <= '0;
      result_index_q <= '0;
      singular_q     <= 1'b1;
      overflowed_q   <= 1'b0;
      last_result_q  <= 1'b1;
    end
  end

  assign result_value_o  = result_value_q;
  assign result_index_o  = result_index_q;
  assign singular_o      = singular_q;
  assign overflowed_o    = overflowed_q;
  assign last_result_o   = last_result_q;
  assign stat_o.div_busy = (iter_q != '0);
  assign stat_o.det_zero = det_zero_q;

  // divider is idle when a division starts
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c1_q.op == OP_DIV_START) |-> (iter_q == '0))
    else $error("division started while divider busy");

  // divider counts down one step per cycle
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iter_q != '0) |=> (iter_q == $past(iter_q) - ITER_W'(1)))
    else $error("divider step count skipped");

  // no division on a zero determinant
  a_div_nonzero_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c1_q.op == OP_DIV_START) |-> !det_zero_q)
    else $error("division started with zero determinant");

endmodule

[sv/m4i_ctrl.sv]
// m4i_ctrl: sequencer for load, adjugate, determinant, divide and emit
// phases; drives the command word and the channel handshakes. Depends on m4i_pkg.
module m4i_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  m4i_pkg::stat_t  stat_i,
  output m4i_pkg::cmd_t   cmd_o
);
  import m4i_pkg::*;

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_COF      = 3'd1;
  localparam logic [2:0] ST_DET      = 3'd2;
  localparam logic [2:0] ST_CHECK    = 3'd3;
  localparam logic [2:0] ST_DIV_RD   = 3'd4;
  localparam logic [2:0] ST_DIV_GAP  = 3'd5;
  localparam logic [2:0] ST_DIV_WAIT = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic [3:0] cnt_q;
  logic [3:0] cnt_d;
  logic [3:0] k_q;
  logic [3:0] k_d;
  logic [3:0] s_q;
  logic [3:0] s_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state and command
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    s_d         = s_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = cmd_idle();
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op     = OP_LOAD;
          cmd_o.addr_a = cnt_q;
          cnt_d        = cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_d = ST_COF;
            k_d     = '0;
            s_d     = '0;
          end
        end
      end
      ST_COF: begin
        cmd_o = cof_cmd(k_q, s_q);
        s_d   = s_q + 4'd1;
        if (s_q == 4'd15) begin
          k_d = k_q + 4'd1;
          if (k_q == 4'd15) begin
            state_d = ST_DET;
          end
        end
      end
      ST_DET: begin
        cmd_o = det_cmd(s_q);
        s_d   = s_q + 4'd1;
        if (s_q == 4'(DET_LAST)) begin
          state_d = ST_CHECK;
          s_d     = '0;
        end
      end
      ST_CHECK: begin
        if (stat_i.det_zero) begin
          if (slot_free) begin
            cmd_o.op    = OP_EMIT_SING;
            out_valid_d = 1'b1;
            state_d     = ST_LOAD;
          end
        end else begin
          k_d     = '0;
          state_d = ST_DIV_RD;
        end
      end
      ST_DIV_RD: begin
        cmd_o.op       = OP_DIV_START;
        cmd_o.cof_addr = k_q;
        state_d        = ST_DIV_GAP;
      end
      ST_DIV_GAP: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat_i.div_busy && slot_free) begin
          cmd_o.op       = OP_EMIT;
          cmd_o.cof_addr = k_q;
          out_valid_d    = 1'b1;
          k_d            = k_q + 4'd1;
          state_d        = (k_q == 4'd15) ? ST_LOAD : ST_DIV_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;

  // a result is only loaded into a free output slot
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT || cmd_o.op == OP_EMIT_SING) |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a waiting beat");

  // adjugate phase hands over to the determinant after the last entry
  a_cof_to_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COF && s_q == 4'd15 && k_q == 4'd15) |=> (state_q == ST_DET))
    else $error("adjugate phase did not end after last entry");

  // last inverse element returns the block to loading
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT && k_q == 4'd15) |=> (state_q == ST_LOAD))
    else $error("block did not return to loading after last result");

endmodule

[sv/matrix4_inverse_cofactor.sv]
// 4x4 matrix inverse by adjugate over determinant, signed Q16.16.
// Sixteen element beats load one per cycle while the block is in its load phase; the last one starts the adjugate
// work on the shared 33x33 multiplier, then the determinant and one check state.
// Each inverse element is then produced by the 33-step restoring divider and emitted in turn.
// Reset is asynchronous, active low; it clears the sequencer, element stores are undefined.
module matrix4_inverse_cofactor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [m4i_pkg::ELEM_W-1:0] element_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [m4i_pkg::ELEM_W-1:0] result_value_o,
  output logic [3:0]                 result_index_o,
  output logic                       singular_o,
  output logic                       overflowed_o,
  output logic                       last_result_o
);
  import m4i_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  m4i_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and stores
  m4i_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .element_value_i (element_value_i),
    .stat_o          (stat),
    .result_value_o  (result_value_o),
    .result_index_o  (result_index_o),
    .singular_o      (singular_o),
    .overflowed_o    (overflowed_o),
    .last_result_o   (last_result_o)
  );

endmodule

[test/matrix4_inverse_cofactor_tb.sv]
// Testbench for matrix4_inverse_cofactor: streams 4x4 Q16.16 matrices and checks
// every inverse element against an in-bench adjugate/determinant predictor.
// Depends on m4i_pkg and the matrix4_inverse_cofactor RTL.
`timescale 1ns / 1ps

class inverse_scoreboard;
  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               singular;
    logic               overflowed;
    logic               last;
  } inv_elem_t;

  logic signed [31:0] elems [16];
  int unsigned        load_cnt;
  inv_elem_t          pending [$];
  int unsigned        mismatches;

  function new();
    load_cnt   = 0;
    mismatches = 0;
  endfunction

  // exact 3x3 determinant of the matrix without row dr and column dc
  function logic signed [127:0] minor3(int dr, int dc);
    int                 r [3];
    int                 c [3];
    int                 nr;
    int                 nc;
    logic signed [127:0] a [3][3];
    nr = 0;
    nc = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != dr) begin r[nr] = i; nr++; end
      if (i != dc) begin c[nc] = i; nc++; end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = 128'(elems[r[i]*4 + c[j]]);
    return a[0][0] * (a[1][1]*a[2][2] - a[1][2]*a[2][1])
         - a[0][1] * (a[1][0]*a[2][2] - a[1][2]*a[2][0])
         + a[0][2] * (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
  endfunction

  // one element beat; the sixteenth completes the matrix
  function void note_element(logic signed [31:0] v);
    logic signed [127:0] adj [16];
    logic                clamp [16];
    logic signed [127:0] det;
    logic signed [127:0] v3;
    logic [127:0]        dmag;
    logic [127:0]        q;
    logic [127:0]        mag;
    inv_elem_t           e;
    elems[load_cnt] = v;
    load_cnt++;
    if (load_cnt < 16) return;
    load_cnt = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        v3 = minor3(j, i);
        if ((i + j) % 2) v3 = -v3;
        v3 = v3 >>> (2*m4i_pkg::FRAC_BITS);
        clamp[i*4+j] = 0;
        if (v3 > 128'sh7FFF_FFFF_FFFF_FFFF) begin
          v3 = 128'sh7FFF_FFFF_FFFF_FFFF; clamp[i*4+j] = 1;
        end else if (v3 < -128'sh8000_0000_0000_0000) begin
          v3 = -128'sh8000_0000_0000_0000; clamp[i*4+j] = 1;
        end
        adj[i*4+j] = v3;
      end
    det = 0;
    for (int j = 0; j < 4; j++) det += 128'(elems[j]) * adj[4*j];
    if (det == 0) begin
      e = '{0, 0, 1, 0, 1};
      pending.push_back(e);
      return;
    end
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < 16; k++) begin
      mag = adj[k] < 0 ? -adj[k] : adj[k];
      q   = (mag << (2*m4i_pkg::FRAC_BITS)) / dmag;
      e.overflowed = clamp[k];
      if ((adj[k] < 0) != (det < 0)) begin
        if (q > 128'h8000_0000) begin e.value = 32'h8000_0000; e.overflowed = 1; end
        else e.value = 32'(-q);
      end else begin
        if (q > 128'h7FFF_FFFF) begin e.value = 32'h7FFF_FFFF; e.overflowed = 1; end
        else e.value = 32'(q);
      end
      e.index    = 4'(k);
      e.singular = 0;
      e.last     = (k == 15);
      pending.push_back(e);
    end
  endfunction

  function void check_result(logic signed [31:0] val, logic [3:0] idx, logic sing,
                             logic ovf, logic last);
    inv_elem_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat idx=%0d val=%h", idx, val);
      return;
    end
    e = pending.pop_front();
    if (e.value !== val || e.index !== idx || e.singular !== sing ||
        e.overflowed !== ovf || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp val=%h idx=%0d sing=%b ovf=%b last=%b, got %h %0d %b %b %b",
                 e.value, e.index, e.singular, e.overflowed, e.last,
                 val, idx, sing, ovf, last);
    end
  endfunction
endclass

module matrix4_inverse_cofactor_tb;
  localparam int LIMIT = 4_000_000;
  localparam int ONE   = 32'h0001_0000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [31:0] element_value_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [31:0] result_value_o;
  logic [3:0]  result_index_o;
  logic        singular_o;
  logic        overflowed_o;
  logic        last_result_o;

  inverse_scoreboard sb = new();
  int unsigned       cycle_cnt = 0;
  bit                calm = 0;
  bit                hold_rx = 0;
  bit                done = 0;

  matrix4_inverse_cofactor uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(result_value_o, result_index_o, singular_o, overflowed_o,
                      last_result_o);
    out_stall_i <= hold_rx || (!calm && $urandom_range(99) < 18);
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT && !done) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one element beat and wait for acceptance
  task automatic send_element(logic [31:0] v);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1;
    element_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_element(v);
  endtask

  task automatic send_matrix(logic [31:0] m [16]);
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (900) @(posedge clk_i);
  endtask

  // random matrix: mostly small values, sometimes full range
  task automatic random_matrix();
    logic [31:0] m [16];
    int          kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: m[i] = $urandom();
        1: m[i] = (i % 5 == 0) ? ONE : 0;
        2: m[i] = i < 4 ? 32'($urandom_range(7)) << 16 : 32'($urandom_range(7)) << 16;
        3: m[i] = 32'(signed'($urandom_range(32)) - 16);
        default: m[i] = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      endcase
    end
    // duplicate a row now and then to hit zero determinant
    if (kind == 2 && $urandom_range(1)) for (int i = 0; i < 4; i++) m[4+i] = m[i];
    send_matrix(m);
  endtask

  initial begin
    logic [31:0] m [16];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identity, extremes, tiny, zero
    calm = 1;
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 0;
    send_matrix(m);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_matrix(m);
    drain();
    calm = 0;
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'd1 : 0;
    send_matrix(m);
    for (int i = 0; i < 16; i++) m[i] = 0;
    send_matrix(m);
    drain();

    // long receiver hold-off while the sender keeps offering beats
    fork
      begin
        hold_rx = 1;
        repeat (3000) @(posedge clk_i);
        hold_rx = 0;
      end
      begin
        random_matrix();
        random_matrix();
        in_valid_i <= 0;
        @(posedge clk_i);
      end
    join

    // random matrices, with a calm stretch in the middle
    for (int n = 0; n < 20; n++) begin
      calm = (n >= 8 && n < 12);
      random_matrix();
      if (n == 15) drain();
    end
    calm = 0;
    drain();

    done = 1;
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
